>>> hw/rtl/led_wave_pulse_envelope_core_macros.svh
// Assertion macros used by the wave envelope core top level.
// Expects clk and rst_n in scope at the point of use.
`ifndef LED_WAVE_PULSE_ENVELOPE_CORE_MACROS_SVH
`define LED_WAVE_PULSE_ENVELOPE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LWPE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LWPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lwpe_pkg.sv
// Package for the wave envelope core: codes, widths, reset values and shared structs.
// No dependencies; the core, config and unit files refer to it by scoped names.
`default_nettype none

package lwpe_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_ACTIVATE = 2'd1;
    localparam logic [1:0] KIND_QUERY    = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REACH    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_DELAY  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIME    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_TIME    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIME     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_COLOR   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_PANEL = 4'd7;

    // Register reset values
    localparam logic [7:0]  RST_MAX_REACH    = 8'd8;
    localparam logic [15:0] RST_PANEL_DELAY  = 16'd50;
    localparam logic [15:0] RST_RISE_TIME    = 16'd200;
    localparam logic [15:0] RST_FALL_TIME    = 16'd400;
    localparam logic [15:0] RST_GAP_TIME     = 16'd500;
    localparam logic [15:0] RST_DECAY_FACTOR = 16'd52429;
    localparam logic [23:0] RST_IDLE_COLOR   = 24'd0;
    localparam logic [7:0]  RST_ORIGIN_PANEL = 8'd0;

    // Reach limit in panels
    localparam logic [7:0] REACH_CAP = 8'd255;

    // Fixed-point constants
    localparam logic [16:0] F_ONE      = 17'd65536;   // 1.0 in Q1.16
    localparam logic [15:0] ENV_ONE    = 16'd32768;   // 1.0 in Q1.15
    localparam logic [31:0] ROUND_HALF = 32'd32768;   // rounding for >> 16

    // Ramp divider: 15 quotient bits, one per step
    localparam int unsigned DIV_STEPS  = 15;
    localparam int unsigned DIV_STEP_W = 4;
    localparam logic [DIV_STEP_W-1:0] DIV_LAST = 4'(DIV_STEPS - 1);

    // Shared unit operations
    typedef enum logic {
        UNIT_MAC   = 1'b0,
        UNIT_DSTEP = 1'b1
    } unit_op_t;

    typedef struct packed {
        unit_op_t    op;
        logic [16:0] a;    // multiplicand, or partial remainder
        logic [15:0] b;    // multiplier, or divisor
        logic [31:0] c;    // addend
    } unit_req_t;

    typedef struct packed {
        logic [32:0] y;    // a*b + c, or new remainder in [16:0]
        logic        qbit; // quotient bit of a division step
    } unit_res_t;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [7:0]  reach;         // clamped reach, 1..REACH_CAP
        logic [15:0] panel_delay;
        logic [15:0] rise_time;
        logic [15:0] fall_time;
        logic [17:0] tail_sum;      // rise + fall + gap
        logic [15:0] decay_factor;
        logic [23:0] idle_color;
        logic [7:0]  origin_panel;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/lwpe_if.sv
// Valid/ready channel interfaces for the wave envelope core.
// Depends on nothing; field widths follow the item definitions.
`default_nettype none

interface lwpe_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  delta_ms;
    logic        sensor_active;
    logic [23:0] new_color;
    logic [7:0]  panel_sel;

    modport source (output valid, kind, delta_ms, sensor_active, new_color, panel_sel,
                    input ready);
    modport sink   (input valid, kind, delta_ms, sensor_active, new_color, panel_sel,
                    output ready);
endinterface

interface lwpe_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] intensity;
    logic [23:0] color;
    logic        wave_active;

    modport source (output valid, intensity, color, wave_active, input ready);
    modport sink   (input valid, intensity, color, wave_active, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/led_wave_pulse_envelope_core.sv
// Wave envelope core top level: sequencer, wave state, output register.
// Depends on lwpe_pkg, lwpe_if, lwpe_cfg, lwpe_unit and the assertion macro header.
//
//   Channel | Direction | Handshake        | Payload
//   --------+-----------+------------------+------------------------------------------
//   cmd     | in        | valid/ready      | kind, delta_ms, sensor_active, new_color,
//           |           |                  | panel_sel
//   rsp     | out       | valid/ready      | intensity, color, wave_active
//   wr_*    | in        | wr_en, no stall  | wr_index, wr_data
//
// One item at a time; cmd.ready is high only while the sequencer is idle.
// Activate, idle tick, idle or out-of-reach query go straight to publish; a running tick
// computes the pulse limit, then checks it. A query computes its panel delay and picks
// the ramp phase; on a ramp it runs 15 division steps, then one multiply per panel.
// A full output register holds the sequencer in its last state until the sink takes it.
// Asynchronous active-low reset clears the wave state and loads register defaults.
`default_nettype none
`include "led_wave_pulse_envelope_core_macros.svh"

module led_wave_pulse_envelope_core (
    input  wire                               clk,
    input  wire                               rst_n,
    lwpe_cmd_if.sink                          cmd,
    lwpe_rsp_if.source                        rsp,
    input  wire                               wr_en,
    input  wire [lwpe_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire [lwpe_pkg::CFG_DATA_W-1:0]    wr_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_TICK  = 10'b00_0000_0010,
        S_TCHK  = 10'b00_0000_0100,
        S_QDLY  = 10'b00_0000_1000,
        S_QENV  = 10'b00_0001_0000,
        S_QFALL = 10'b00_0010_0000,
        S_QDIV  = 10'b00_0100_0000,
        S_QPOW  = 10'b00_1000_0000,
        S_QMIX  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

    lwpe_pkg::cfg_t      cfg;
    lwpe_pkg::unit_req_t ureq;
    lwpe_pkg::unit_res_t ures;

    state_t      state_reg,      state_next;
    logic        prop_reg,       prop_next;
    logic [31:0] elapsed_reg,    elapsed_next;
    logic [23:0] color_reg,      color_next;
    logic        sensor_reg,     sensor_next;
    logic [7:0]  dist_reg,       dist_next;
    logic [32:0] acc_reg,        acc_next;
    logic [15:0] intensity_reg,  intensity_next;
    logic [16:0] rem_reg,        rem_next;
    logic [15:0] div_reg,        div_next;
    logic [14:0] quo_reg,        quo_next;
    logic        fall_mode_reg,  fall_mode_next;
    logic [lwpe_pkg::DIV_STEP_W-1:0] step_reg, step_next;
    logic [7:0]  pow_cnt_reg,    pow_cnt_next;
    logic [16:0] f_reg,          f_next;
    logic [15:0] env_reg,        env_next;
    logic        out_valid_reg,  out_valid_next;
    logic [15:0] out_int_reg,    out_int_next;
    logic [23:0] out_color_reg,  out_color_next;
    logic        out_active_reg, out_active_next;

    logic        take;
    logic [32:0] sat_sum;
    logic [7:0]  dist_abs;
    logic [32:0] t_diff;
    logic [14:0] quo_final;

    lwpe_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    lwpe_unit u_unit (
        .req (ureq),
        .res (ures)
    );

    // Handshake and port drive
    assign cmd.ready       = (state_reg == S_IDLE);
    assign take            = cmd.valid && cmd.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.intensity   = out_int_reg;
    assign rsp.color       = out_color_reg;
    assign rsp.wave_active = out_active_reg;

    // Helpers: saturating timer add, panel distance, delayed time, final quotient
    always_comb
    begin
        sat_sum   = {1'b0, elapsed_reg} + {25'd0, cmd.delta_ms};
        dist_abs  = (cmd.panel_sel >= cfg.origin_panel)
                  ? (cmd.panel_sel - cfg.origin_panel)
                  : (cfg.origin_panel - cmd.panel_sel);
        t_diff    = {1'b0, elapsed_reg} - {1'b0, acc_reg[31:0]};
        quo_final = {quo_reg[13:0], ures.qbit};
    end

    // Route operands to the shared unit
    always_comb
    begin
        ureq    = '0;
        ureq.op = lwpe_pkg::UNIT_MAC;
        case (state_reg)
            S_TICK:
            begin
                ureq.a = {9'd0, cfg.reach};
                ureq.b = cfg.panel_delay;
                ureq.c = {14'd0, cfg.tail_sum};
            end
            S_QDLY:
            begin
                ureq.a = {9'd0, dist_reg};
                ureq.b = cfg.panel_delay;
            end
            S_QDIV:
            begin
                ureq.op = lwpe_pkg::UNIT_DSTEP;
                ureq.a  = rem_reg;
                ureq.b  = div_reg;
            end
            S_QPOW:
            begin
                ureq.a = f_reg;
                ureq.b = cfg.decay_factor;
                ureq.c = lwpe_pkg::ROUND_HALF;
            end
            S_QMIX:
            begin
                ureq.a = f_reg;
                ureq.b = env_reg;
                ureq.c = lwpe_pkg::ROUND_HALF;
            end
            default:
            begin
                ureq = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        prop_next       = prop_reg;
        elapsed_next    = elapsed_reg;
        color_next      = color_reg;
        sensor_next     = sensor_reg;
        dist_next       = dist_reg;
        acc_next        = acc_reg;
        intensity_next  = intensity_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        quo_next        = quo_reg;
        fall_mode_next  = fall_mode_reg;
        step_next       = step_reg;
        pow_cnt_next    = pow_cnt_reg;
        f_next          = f_reg;
        env_next        = env_reg;
        out_valid_next  = out_valid_reg;
        out_int_next    = out_int_reg;
        out_color_next  = out_color_reg;
        out_active_next = out_active_reg;

        // Drop the result once the sink takes it
        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    intensity_next = 16'd0;
                    sensor_next    = cmd.sensor_active;
                    dist_next      = dist_abs;
                    state_next     = S_DONE;
                    case (cmd.kind)
                        lwpe_pkg::KIND_TICK:
                        begin
                            if (prop_reg)
                            begin
                                elapsed_next = sat_sum[32] ? '1 : sat_sum[31:0];
                                state_next   = S_TICK;
                            end
                        end
                        lwpe_pkg::KIND_ACTIVATE:
                        begin
                            color_next   = cmd.new_color;
                            elapsed_next = 32'd0;
                            prop_next    = 1'b1;
                        end
                        lwpe_pkg::KIND_QUERY:
                        begin
                            if (prop_reg && (dist_abs <= cfg.reach))
                                state_next = S_QDLY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Pulse limit: reach * delay + rise + fall + gap
            S_TICK:
            begin
                acc_next   = ures.y;
                state_next = S_TCHK;
            end

            // Restart or go idle once the timer reaches the limit
            S_TCHK:
            begin
                if ({1'b0, elapsed_reg} >= acc_reg)
                begin
                    if (sensor_reg)
                        elapsed_next = 32'd0;
                    else
                    begin
                        prop_next  = 1'b0;
                        color_next = cfg.idle_color;
                    end
                end
                state_next = S_DONE;
            end

            // Panel delay: distance * delay
            S_QDLY:
            begin
                acc_next   = ures.y;
                state_next = S_QENV;
            end

            // Pick the ramp phase of the delayed time
            S_QENV:
            begin
                if (t_diff[32] || (t_diff == 33'd0))
                    state_next = S_DONE;
                else if (t_diff[31:0] < {16'd0, cfg.rise_time})
                begin
                    rem_next       = {1'b0, t_diff[15:0]};
                    div_next       = cfg.rise_time;
                    fall_mode_next = 1'b0;
                    step_next      = '0;
                    state_next     = S_QDIV;
                end
                else
                begin
                    acc_next   = {1'b0, t_diff[31:0] - {16'd0, cfg.rise_time}};
                    state_next = S_QFALL;
                end
            end

            S_QFALL:
            begin
                if (acc_reg[31:0] < {16'd0, cfg.fall_time})
                begin
                    rem_next       = {1'b0, acc_reg[15:0]};
                    div_next       = cfg.fall_time;
                    fall_mode_next = 1'b1;
                    step_next      = '0;
                    state_next     = S_QDIV;
                end
                else
                    state_next = S_DONE;
            end

            // One quotient bit per cycle of time * 32768 / ramp length
            S_QDIV:
            begin
                rem_next  = ures.y[16:0];
                quo_next  = quo_final;
                step_next = step_reg + 1'b1;
                if (step_reg == lwpe_pkg::DIV_LAST)
                begin
                    env_next     = fall_mode_reg ? (lwpe_pkg::ENV_ONE - {1'b0, quo_final})
                                                 : {1'b0, quo_final};
                    f_next       = lwpe_pkg::F_ONE;
                    pow_cnt_next = dist_reg;
                    state_next   = (dist_reg == 8'd0) ? S_QMIX : S_QPOW;
                end
            end

            // Falloff: one rounded decay multiply per panel of distance
            S_QPOW:
            begin
                f_next       = ures.y[32:16];
                pow_cnt_next = pow_cnt_reg - 8'd1;
                if (pow_cnt_reg == 8'd1)
                    state_next = S_QMIX;
            end

            // Intensity: falloff times envelope, rounded
            S_QMIX:
            begin
                intensity_next = ures.y[31:16];
                state_next     = S_DONE;
            end

            // Hold until the output register is free, then publish
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_int_next    = intensity_reg;
                    out_color_next  = color_reg;
                    out_active_next = prop_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and wave state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prop_reg      <= 1'b0;
            elapsed_reg   <= 32'd0;
            color_reg     <= 24'd0;
            step_reg      <= '0;
            pow_cnt_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prop_reg      <= prop_next;
            elapsed_reg   <= elapsed_next;
            color_reg     <= color_next;
            step_reg      <= step_next;
            pow_cnt_reg   <= pow_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        sensor_reg     <= sensor_next;
        dist_reg       <= dist_next;
        acc_reg        <= acc_next;
        intensity_reg  <= intensity_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        quo_reg        <= quo_next;
        fall_mode_reg  <= fall_mode_next;
        f_reg          <= f_next;
        env_reg        <= env_next;
        out_int_reg    <= out_int_next;
        out_color_reg  <= out_color_next;
        out_active_reg <= out_active_next;
    end

    // Checks on the sequencer and the fixed-point ranges
    `LWPE_ASSERT_NEXT(a_idle_query_short,
        take && (cmd.kind == lwpe_pkg::KIND_QUERY) && !prop_reg,
        state_reg == S_DONE, "idle query did not finish at once")
    `LWPE_ASSERT_SAME(a_falloff_range,
        (state_reg == S_QPOW) || (state_reg == S_QMIX),
        f_reg <= lwpe_pkg::F_ONE, "falloff above one")
    `LWPE_ASSERT_SAME(a_envelope_range,
        (state_reg == S_QPOW) || (state_reg == S_QMIX),
        env_reg <= lwpe_pkg::ENV_ONE, "envelope above one")
    `LWPE_ASSERT_NEXT(a_done_waits,
        (state_reg == S_DONE) && out_valid_reg && !rsp.ready,
        state_reg == S_DONE, "result overwrote a pending transaction")

endmodule

`default_nettype wire

>>> hw/rtl/lwpe_unit.sv
// Shared arithmetic unit: one multiply-add, or one restoring division step.
// Depends on lwpe_pkg for the request and result structs.
`default_nettype none

module lwpe_unit (
    input  wire lwpe_pkg::unit_req_t req,
    output lwpe_pkg::unit_res_t      res
);

    logic [32:0] prod;
    logic [32:0] mac;
    logic [16:0] shifted;
    logic [16:0] divisor;
    logic        fits;

    // Multiply-add: 17x16 product plus a 32-bit addend
    always_comb
    begin
        prod = {16'd0, req.a} * {17'd0, req.b};
        mac  = prod + {1'b0, req.c};
    end

    // Division step: shift remainder left, subtract divisor where it fits
    always_comb
    begin
        shifted = {req.a[15:0], 1'b0};
        divisor = {1'b0, req.b};
        fits    = (shifted >= divisor);
    end

    always_comb
    begin
        res = '0;
        case (req.op)
            lwpe_pkg::UNIT_MAC:
            begin
                res.y    = mac;
                res.qbit = 1'b0;
            end
            lwpe_pkg::UNIT_DSTEP:
            begin
                res.y    = {16'd0, (fits ? (shifted - divisor) : shifted)};
                res.qbit = fits;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/lwpe_cfg.sv
// Configuration register file: write decode, reset values, reach clamp, pulse tail sum.
// Depends on lwpe_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module lwpe_cfg (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               wr_en,
    input  wire [lwpe_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire [lwpe_pkg::CFG_DATA_W-1:0]    wr_data,
    output lwpe_pkg::cfg_t                    cfg
);

    logic [7:0]  max_reach_reg;
    logic [15:0] panel_delay_reg;
    logic [15:0] rise_time_reg;
    logic [15:0] fall_time_reg;
    logic [15:0] gap_time_reg;
    logic [15:0] decay_factor_reg;
    logic [23:0] idle_color_reg;
    logic [7:0]  origin_panel_reg;

    // Decode writes; indexes beyond the list fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reach_reg    <= lwpe_pkg::RST_MAX_REACH;
            panel_delay_reg  <= lwpe_pkg::RST_PANEL_DELAY;
            rise_time_reg    <= lwpe_pkg::RST_RISE_TIME;
            fall_time_reg    <= lwpe_pkg::RST_FALL_TIME;
            gap_time_reg     <= lwpe_pkg::RST_GAP_TIME;
            decay_factor_reg <= lwpe_pkg::RST_DECAY_FACTOR;
            idle_color_reg   <= lwpe_pkg::RST_IDLE_COLOR;
            origin_panel_reg <= lwpe_pkg::RST_ORIGIN_PANEL;
        end
        else if (wr_en)
        begin
            case (wr_index)
                lwpe_pkg::CFG_MAX_REACH:    max_reach_reg    <= wr_data[7:0];
                lwpe_pkg::CFG_PANEL_DELAY:  panel_delay_reg  <= wr_data[15:0];
                lwpe_pkg::CFG_RISE_TIME:    rise_time_reg    <= wr_data[15:0];
                lwpe_pkg::CFG_FALL_TIME:    fall_time_reg    <= wr_data[15:0];
                lwpe_pkg::CFG_GAP_TIME:     gap_time_reg     <= wr_data[15:0];
                lwpe_pkg::CFG_DECAY_FACTOR: decay_factor_reg <= wr_data[15:0];
                lwpe_pkg::CFG_IDLE_COLOR:   idle_color_reg   <= wr_data[23:0];
                lwpe_pkg::CFG_ORIGIN_PANEL: origin_panel_reg <= wr_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Clamp reach to at least one panel and at most the distance limit
    always_comb
    begin
        cfg = '0;
        if (max_reach_reg == 8'd0)
            cfg.reach = 8'd1;
        else if (max_reach_reg > lwpe_pkg::REACH_CAP)
            cfg.reach = lwpe_pkg::REACH_CAP;
        else
            cfg.reach = max_reach_reg;
        cfg.panel_delay  = panel_delay_reg;
        cfg.rise_time    = rise_time_reg;
        cfg.fall_time    = fall_time_reg;
        cfg.tail_sum     = {2'd0, rise_time_reg} + {2'd0, fall_time_reg}
                         + {2'd0, gap_time_reg};
        cfg.decay_factor = decay_factor_reg;
        cfg.idle_color   = idle_color_reg;
        cfg.origin_panel = origin_panel_reg;
    end

endmodule

`default_nettype wire
